// ===== rtl/affine_point_transform_assert.svh =====
// assertion shorthands, clocked on clk and held off during reset
`ifndef AFFINE_POINT_TRANSFORM_ASSERT_SVH
`define AFFINE_POINT_TRANSFORM_ASSERT_SVH

// same-cycle implication
`define APT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define APT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/apt_pkg.sv =====
package apt_pkg;

	localparam int COORD_BITS = 32;
	localparam int FRAC_BITS  = 16;

	localparam int IO_W     = 32;
	localparam int REG_W    = 64;
	localparam int HALF_W   = REG_W / 2;
	localparam int NUM_REGS = 6;
	localparam int IDX_W    = $clog2(NUM_REGS);
	localparam int NUM_ROWS = 3;
	localparam int NUM_COLS = 3;

	localparam int PROD_W = 2 * COORD_BITS;
	localparam int SHP_W  = PROD_W - FRAC_BITS;
	localparam int SUM_W  = SHP_W + 2;

	localparam logic signed [IO_W-1:0] Q_MAX = IO_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
	localparam logic signed [IO_W-1:0] Q_MIN = ~Q_MAX;

	localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(Q_MAX);
	localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(Q_MIN);

	// register indexes
	localparam logic [IDX_W-1:0] REG_ROW0_LIN_XY = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_ROW0_Z_OFF  = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_ROW1_LIN_XY = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_ROW1_Z_OFF  = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_ROW2_LIN_XY = IDX_W'(4);
	localparam logic [IDX_W-1:0] REG_ROW2_Z_OFF  = IDX_W'(5);

	// identity matrix, zero translation
	localparam logic [REG_W-1:0] CFG_RESET [NUM_REGS] = '{
		REG_W'(64'h0000_0000_0001_0000),
		REG_W'(64'h0000_0000_0000_0000),
		REG_W'(64'h0001_0000_0000_0000),
		REG_W'(64'h0000_0000_0000_0000),
		REG_W'(64'h0000_0000_0000_0000),
		REG_W'(64'h0000_0000_0001_0000)
	};

	typedef struct packed {
		logic signed [IO_W-1:0] px;
		logic signed [IO_W-1:0] py;
		logic signed [IO_W-1:0] pz;
	} in_word_t;

	typedef struct packed {
		logic signed [IO_W-1:0] qx;
		logic signed [IO_W-1:0] qy;
		logic signed [IO_W-1:0] qz;
		logic                   clipped;
	} out_word_t;

endpackage

// ===== rtl/affine_point_transform.sv =====
// Affine point transform: each point (px,py,pz) on the input channel gives one point
// q = M * (p,1) on the output channel, where M is the 3x4 matrix held in six 64-bit
// registers (identity at reset). One point is taken every cycle unless a stalled output
// backs the pipeline up; a taken point passes in order through the input register, the
// nine parallel multipliers, shift-and-sum and the saturation/output register. When the
// output is stalled, the pipeline fills and in_ready drops once all four stages hold a
// point. Products are floored by the fractional shift, each row sum saturates to the
// coordinate range, and clipped flags a point in which any coordinate saturated. Matrix
// writes take effect at once and belong only to times when no point is in flight.
module affine_point_transform (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  apt_pkg::in_word_t        in_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output apt_pkg::out_word_t       out_data,
	input  logic                     cfg_we,
	input  logic [apt_pkg::IDX_W-1:0] cfg_index,
	input  logic [apt_pkg::REG_W-1:0] cfg_data
);
	import apt_pkg::*;

	logic [REG_W-1:0] cfg_q [NUM_REGS];

	logic signed [COORD_BITS-1:0] coef [NUM_ROWS][NUM_COLS];
	logic signed [COORD_BITS-1:0] offs [NUM_ROWS];

	logic                         v_s1, v_s2, v_s3, v_s4;
	logic signed [COORD_BITS-1:0] p_s1    [NUM_COLS];
	logic signed [PROD_W-1:0]     prod_s2 [NUM_ROWS][NUM_COLS];
	logic signed [SUM_W-1:0]      sum_s3  [NUM_ROWS];
	logic signed [IO_W-1:0]       q_s4    [NUM_ROWS];
	logic                         clip_s4;

	logic en_s2, en_s3, en_s4;

	logic signed [COORD_BITS-1:0] q_sat [NUM_ROWS];
	logic [NUM_ROWS-1:0]          row_clip;

	// matrix registers, out-of-range index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cfg_q[i] <= CFG_RESET[i];
			end
		end else if (cfg_we && (cfg_index <= REG_ROW2_Z_OFF)) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	always_comb begin
		for (int r = 0; r < NUM_ROWS; r++) begin
			coef[r][0] = cfg_q[2*r][COORD_BITS-1:0];
			coef[r][1] = cfg_q[2*r][HALF_W+COORD_BITS-1:HALF_W];
			coef[r][2] = cfg_q[2*r+1][COORD_BITS-1:0];
			offs[r]    = cfg_q[2*r+1][HALF_W+COORD_BITS-1:HALF_W];
		end
	end

	// stage advance, from the output back
	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign in_ready = !v_s1 || en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (en_s2)    v_s2 <= v_s1;
			if (en_s3)    v_s3 <= v_s2;
			if (en_s4)    v_s4 <= v_s3;
		end
	end

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			p_s1[0] <= in_data.px[COORD_BITS-1:0];
			p_s1[1] <= in_data.py[COORD_BITS-1:0];
			p_s1[2] <= in_data.pz[COORD_BITS-1:0];
		end
	end

	// stage 2: nine products
	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			for (int r = 0; r < NUM_ROWS; r++) begin
				for (int c = 0; c < NUM_COLS; c++) begin
					prod_s2[r][c] <= coef[r][c] * p_s1[c];
				end
			end
		end
	end

	// stage 3: floor each product by the fraction shift, add the offset
	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			for (int r = 0; r < NUM_ROWS; r++) begin
				sum_s3[r] <= SUM_W'(prod_s2[r][0] >>> FRAC_BITS)
					+ SUM_W'(prod_s2[r][1] >>> FRAC_BITS)
					+ SUM_W'(prod_s2[r][2] >>> FRAC_BITS)
					+ SUM_W'(offs[r]);
			end
		end
	end

	// stage 4: saturate to the coordinate range
	always_comb begin
		for (int r = 0; r < NUM_ROWS; r++) begin
			if (sum_s3[r] > SUM_MAX) begin
				q_sat[r]    = Q_MAX[COORD_BITS-1:0];
				row_clip[r] = 1'b1;
			end else if (sum_s3[r] < SUM_MIN) begin
				q_sat[r]    = Q_MIN[COORD_BITS-1:0];
				row_clip[r] = 1'b1;
			end else begin
				q_sat[r]    = sum_s3[r][COORD_BITS-1:0];
				row_clip[r] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			for (int r = 0; r < NUM_ROWS; r++) begin
				q_s4[r] <= IO_W'(q_sat[r]);
			end
			clip_s4 <= |row_clip;
		end
	end

	assign out_valid        = v_s4;
	assign out_data.qx      = q_s4[0];
	assign out_data.qy      = q_s4[1];
	assign out_data.qz      = q_s4[2];
	assign out_data.clipped = clip_s4;

endmodule

// ===== rtl/apt_chk.sv =====
`include "affine_point_transform_assert.svh"

module apt_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input apt_pkg::in_word_t  in_data,
	input logic               out_valid,
	input logic               out_ready,
	input apt_pkg::out_word_t out_data
);
	import apt_pkg::*;

	// a stalled result word holds
	`APT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output word changed while stalled")

	// an open output never backs up the input
	`APT_ASSERT_IMP(a_ready_flow, out_ready, in_ready, "input stalled while output is open")

	// a taken point reaches the output when the output keeps taking words
	`APT_ASSERT_NXT(a_latency, (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready, out_valid, "result word missing after pipeline latency")

	// a clipped point has a coordinate at a range limit
	`APT_ASSERT_IMP(a_clip_limit, out_valid && out_data.clipped, (out_data.qx == Q_MAX) || (out_data.qx == Q_MIN) || (out_data.qy == Q_MAX) || (out_data.qy == Q_MIN) || (out_data.qz == Q_MAX) || (out_data.qz == Q_MIN), "clipped set with no saturated coordinate")

endmodule

bind affine_point_transform apt_chk u_apt_chk (.*);

// ===== tb/affine_point_transform_tb.sv =====
module affine_point_transform_tb;
	import apt_pkg::*;

	localparam int CYCLE_LIMIT      = 200000;
	localparam int NUM_PHASES       = 10;
	localparam int POINTS_PER_PHASE = 190;
	localparam int STEADY_PHASE     = 6;
	localparam int DRAIN_CYCLES     = 8;
	localparam int MAX_REPORTS      = 20;
	localparam int IDLE_PCT         = 18;

	// indexes past the last register, writes there must be dropped
	localparam logic [IDX_W-1:0] REG_UNMAPPED_LO = IDX_W'(6);
	localparam logic [IDX_W-1:0] REG_UNMAPPED_HI = IDX_W'(7);

	localparam logic [REG_W-1:0] RESET_MATRIX [NUM_REGS] = '{
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000
	};

	localparam logic [IO_W-1:0] EDGE_VALUES [7] = '{
		32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
		32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001
	};

	typedef enum logic [1:0] {ROW_WRITE, ROW_POINT, ROW_POINT_CHK} row_kind_t;
	typedef enum logic [1:0] {SPAN_FULL, SPAN_NEAR, SPAN_EDGE} span_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [IDX_W-1:0]  idx;
		logic [REG_W-1:0]  val;
		in_word_t          pt;
		out_word_t         want;
	} stim_row_t;

	localparam int NUM_DIRECTED = 25;
	localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
		// identity after reset
		'{ROW_POINT_CHK, '0, '0, '{32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000},
			'{32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 1'b0}},
		'{ROW_POINT_CHK, '0, '0, '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000},
			'{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0}},
		'{ROW_POINT_CHK, '0, '0, '{32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0000_0001},
			'{32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0000_0001, 1'b0}},
		'{ROW_POINT_CHK, '0, '0, '{32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF},
			'{32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0}},
		// x doubled: saturates high and low
		'{ROW_WRITE, REG_ROW0_LIN_XY, 64'h0000_0000_0002_0000, '0, '0},
		'{ROW_POINT_CHK, '0, '0, '{32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000},
			'{32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1}},
		'{ROW_POINT_CHK, '0, '0, '{32'h8000_0000, 32'h0000_0000, 32'h0000_0000},
			'{32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1}},
		// offset at the top of the range: exactly max is not a clip
		'{ROW_WRITE, REG_ROW0_Z_OFF, 64'h7FFF_FFFF_0000_0000, '0, '0},
		'{ROW_POINT_CHK, '0, '0, '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
			'{32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0}},
		'{ROW_POINT_CHK, '0, '0, '{32'h0000_8000, 32'h0000_0000, 32'h0000_0000},
			'{32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1}},
		'{ROW_WRITE, REG_UNMAPPED_LO, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0},
		'{ROW_WRITE, REG_UNMAPPED_HI, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0},
		'{ROW_POINT_CHK, '0, '0, '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
			'{32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0}},
		// smallest negative coefficient: products floor toward minus infinity
		'{ROW_WRITE, REG_ROW0_Z_OFF, 64'h0000_0000_0000_0000, '0, '0},
		'{ROW_WRITE, REG_ROW1_LIN_XY, 64'h0000_0000_FFFF_FFFF, '0, '0},
		'{ROW_POINT_CHK, '0, '0, '{32'h0000_0001, 32'h0000_0000, 32'h0000_0000},
			'{32'h0000_0002, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0}},
		'{ROW_POINT_CHK, '0, '0, '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000},
			'{32'hFFFF_FFFE, 32'h0000_0000, 32'h0000_0000, 1'b0}},
		// most negative everything on row 2
		'{ROW_WRITE, REG_ROW2_LIN_XY, 64'h8000_0000_8000_0000, '0, '0},
		'{ROW_WRITE, REG_ROW2_Z_OFF, 64'h8000_0000_8000_0000, '0, '0},
		'{ROW_POINT, '0, '0, '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, '0},
		'{ROW_POINT, '0, '0, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, '0},
		'{ROW_POINT, '0, '0, '{32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678}, '0},
		'{ROW_WRITE, REG_ROW1_Z_OFF, 64'hFFFF_8000_7FFF_FFFF, '0, '0},
		'{ROW_POINT, '0, '0, '{32'hDEAD_BEEF, 32'h1357_9BDF, 32'h0246_8ACE}, '0},
		'{ROW_POINT, '0, '0, '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}, '0}
	};

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	in_word_t          in_data   = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_word_t         out_data;
	logic              cfg_we    = 1'b0;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [REG_W-1:0]  cfg_data  = '0;

	logic [REG_W-1:0] matrix_regs [NUM_REGS] = RESET_MATRIX;
	out_word_t        pending_points [$];
	bit               no_idle         = 1'b0;
	int               mismatch_count  = 0;
	int               points_sent     = 0;
	int               settings_loaded = 0;
	int               clipped_seen    = 0;
	int               cycle_count     = 0;

	affine_point_transform DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic out_word_t transform_point(in_word_t p);
		out_word_t        q;
		longint           coord [3];
		longint           acc;
		logic [REG_W-1:0] lin;
		logic [REG_W-1:0] zo;
		logic [IO_W-1:0]  row_out [3];
		q.clipped = 1'b0;
		coord[0] = longint'(signed'(p.px));
		coord[1] = longint'(signed'(p.py));
		coord[2] = longint'(signed'(p.pz));
		for (int r = 0; r < NUM_ROWS; r++) begin
			lin = matrix_regs[2 * r];
			zo  = matrix_regs[2 * r + 1];
			acc = ((longint'(signed'(lin[31:0])) * coord[0]) >>> FRAC_BITS)
			    + ((longint'(signed'(lin[63:32])) * coord[1]) >>> FRAC_BITS)
			    + ((longint'(signed'(zo[31:0])) * coord[2]) >>> FRAC_BITS)
			    + longint'(signed'(zo[63:32]));
			if (acc > longint'(Q_MAX)) begin
				acc = longint'(Q_MAX);
				q.clipped = 1'b1;
			end else if (acc < longint'(Q_MIN)) begin
				acc = longint'(Q_MIN);
				q.clipped = 1'b1;
			end
			row_out[r] = acc[31:0];
		end
		q.qx = row_out[0];
		q.qy = row_out[1];
		q.qz = row_out[2];
		return q;
	endfunction

	function automatic logic [IO_W-1:0] rand_half(span_t span);
		logic [IO_W-1:0] v;
		case (span)
			SPAN_FULL: v = $urandom;
			// within +/-16.0, keeps sums in range
			SPAN_NEAR: v = $urandom_range(32'h0020_0000) - 32'h0010_0000;
			default: v = EDGE_VALUES[$urandom_range(6)];
		endcase
		return v;
	endfunction

	function automatic span_t point_span();
		int unsigned k;
		k = $urandom_range(9);
		return (k < 4) ? SPAN_FULL : (k < 8) ? SPAN_NEAR : SPAN_EDGE;
	endfunction

	task automatic drive_point(in_word_t p, out_word_t want);
		int gap;
		gap = 0;
		while (!no_idle && $urandom_range(99) < IDLE_PCT)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= p;
		do @(posedge clk); while (!in_ready);
		pending_points.push_back(want);
		points_sent++;
	endtask

	// matrix writes only with the pipeline empty
	task automatic load_matrix_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
		in_valid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx < NUM_REGS)
			matrix_regs[idx] = val;
		@(posedge clk);
	endtask

	always @(posedge clk) out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: no progress after %0d cycles", $time, cycle_count);
			$display("** affine_point_transform: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_points.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: unexpected word, expected none, got q=(%0d,%0d,%0d) clipped=%0b",
						$time, out_data.qx, out_data.qy, out_data.qz, out_data.clipped);
			end else begin
				want = pending_points.pop_front();
				if (want.clipped)
					clipped_seen++;
				if (out_data.qx !== want.qx || out_data.qy !== want.qy ||
				    out_data.qz !== want.qz || out_data.clipped !== want.clipped) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: expected q=(%0d,%0d,%0d) clipped=%0b, got q=(%0d,%0d,%0d) clipped=%0b",
							$time, want.qx, want.qy, want.qz, want.clipped,
							out_data.qx, out_data.qy, out_data.qz, out_data.clipped);
				end
			end
		end
	end

	initial begin
		stim_row_t        row;
		in_word_t         p;
		logic [REG_W-1:0] cfg_word;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			row = DIRECTED_ROWS[i];
			case (row.kind)
				ROW_WRITE: load_matrix_reg(row.idx, row.val);
				ROW_POINT: drive_point(row.pt, transform_point(row.pt));
				default:   drive_point(row.pt, row.want);
			endcase
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			no_idle = (ph == STEADY_PHASE);
			for (int r = 0; r < NUM_REGS; r++) begin
				case (ph)
					0: cfg_word = RESET_MATRIX[r];
					1: cfg_word = {rand_half(SPAN_EDGE), rand_half(SPAN_EDGE)};
					2, 3: cfg_word = {rand_half(SPAN_NEAR), rand_half(SPAN_NEAR)};
					default: cfg_word = {rand_half(span_t'($urandom_range(2))),
						rand_half(span_t'($urandom_range(2)))};
				endcase
				load_matrix_reg(IDX_W'(r), cfg_word);
			end
			if (ph % 3 == 0)
				load_matrix_reg((ph % 2 != 0) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO,
					{$urandom, $urandom});
			settings_loaded++;
			for (int n = 0; n < POINTS_PER_PHASE; n++) begin
				p.px = rand_half(point_span());
				p.py = rand_half(point_span());
				p.pz = rand_half(point_span());
				drive_point(p, transform_point(p));
			end
		end

		in_valid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d points: directed cases and %0d matrix settings, %0d saturated",
			points_sent, settings_loaded, clipped_seen);
		if (mismatch_count == 0)
			$display("** affine_point_transform: PASSED **");
		else
			$display("** affine_point_transform: FAILED **");
		$finish;
	end

endmodule
